>>> hw/rtl/esfc_pkg.sv
// Shared types and constants for the encoder SYNC frame collector.
package esfc_pkg;

	localparam int SLOTS       = 4;
	localparam int MODULES_DEF = 4;
	localparam int QDEPTH      = 4;

	localparam logic [10:0] HB_BASE  = 11'h700;
	localparam logic [10:0] HB_TOP   = 11'h77F;
	localparam logic [10:0] SYNC_ID  = 11'h080;
	localparam logic [3:0]  HB_LEN   = 4'd1;
	localparam logic [3:0]  POS_LEN  = 4'd4;
	localparam logic [15:0] CNT_MAX  = 16'hFFFF;

	// configuration register indexes
	localparam logic [2:0] REG_NODE0      = 3'd0;
	localparam logic [2:0] REG_NODE1      = 3'd1;
	localparam logic [2:0] REG_NODE2      = 3'd2;
	localparam logic [2:0] REG_NODE3      = 3'd3;
	localparam logic [2:0] REG_HB_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_PDO_BASE   = 3'd5;

	localparam logic [15:0] HB_TIMEOUT_RST = 16'd300;
	localparam logic [10:0] PDO_BASE_RST   = 11'd640;

	// frame counter slots
	localparam int CNT_STALE   = 0;
	localparam int CNT_UNKNOWN = 1;
	localparam int CNT_REJECT  = 2;
	localparam int CNT_DUP     = 3;

	localparam logic KIND_SYNC   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_FRAME  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_t;

	// classified item as it travels from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic        hb_hit;
		logic [1:0]  hb_slot;
		logic        pdo_hit;
		logic [1:0]  pdo_slot;
		logic        len_ok;
		logic [31:0] payload;
		logic [31:0] rx_time;
	} entry_t;

	typedef struct packed {
		logic        kind;
		logic [10:0] sync_can_id;
		logic [1:0]  module_index;
		logic [31:0] position;
		logic        position_valid;
		logic        heartbeat_alive;
		logic [7:0]  hb_state;
		logic [15:0] stale_count;
		logic [15:0] unknown_count;
		logic [15:0] rejected_count;
		logic [15:0] duplicate_count;
		logic        last;
	} result_t;

endpackage

>>> hw/rtl/encoder_sync_frame_collector_unit.sv
// Top level of the encoder SYNC frame collector.
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tuser command, s_tdata frame fields
//  m_*       out        m_tvalid / m_tready     m_tuser kind, m_tdata report, m_tlast
//  cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Frames and ticks retire one per cycle at the head of the queue; a start yields
// one result, a report one per active slot, each waiting on the single result register.
// Input items pass through a four-entry queue, so s_tready stays high while
// the output is stalled until that queue fills. Reset clears all cycle,
// heartbeat and counter state at once; there is no clearing pass.
module encoder_sync_frame_collector_unit #(
	parameter int MODULES = esfc_pkg::MODULES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // command
	input  logic [79:0]  s_tdata,   // can_id, frame_length, payload_low, rx_time, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [0:0]   m_tuser,   // result_kind
	output logic [119:0] m_tdata,   // sync_can_id, module_index, position, position_valid,
	                                // heartbeat_alive, hb_state, stale_count,
	                                // unknown_count, rejected_count, duplicate_count, pad
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	esfc_pkg::entry_t  entry;
	esfc_pkg::entry_t  head;
	esfc_pkg::result_t res;
	logic              head_valid;
	logic              pop;
	logic              full;
	logic [15:0]       hb_timeout;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;

	esfc_front #(.MODULES(MODULES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (esfc_pkg::cmd_t'(s_tuser)),
		.can_id       (s_tdata[10:0]),
		.frame_length (s_tdata[14:11]),
		.payload_low  (s_tdata[46:15]),
		.rx_time      (s_tdata[78:47]),
		.entry        (entry),
		.hb_timeout   (hb_timeout)
	);

	esfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_data  (entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	esfc_back #(.MODULES(MODULES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.hb_timeout (hb_timeout),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (res)
	);

	assign m_tuser = res.kind;
	assign m_tlast = res.last;
	assign m_tdata = {1'b0,
		res.duplicate_count, res.rejected_count, res.unknown_count, res.stale_count,
		res.hb_state, res.heartbeat_alive, res.position_valid, res.position,
		res.module_index, res.sync_can_id};

endmodule

>>> hw/rtl/esfc_front.sv
// Front end: configuration registers and frame classification against them.
module esfc_front #(
	parameter int MODULES = esfc_pkg::MODULES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  esfc_pkg::cmd_t    cmd,
	input  logic [10:0]       can_id,
	input  logic [3:0]        frame_length,
	input  logic [31:0]       payload_low,
	input  logic [31:0]       rx_time,
	output esfc_pkg::entry_t  entry,
	output logic [15:0]       hb_timeout
);

	localparam int ACTIVE = (MODULES < esfc_pkg::SLOTS) ? MODULES : esfc_pkg::SLOTS;

	logic [6:0]  node_q [esfc_pkg::SLOTS];
	logic [15:0] timeout_q;
	logic [10:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < esfc_pkg::SLOTS; i++) begin
				node_q[i] <= 7'(i + 1);
			end
			timeout_q <= esfc_pkg::HB_TIMEOUT_RST;
			base_q    <= esfc_pkg::PDO_BASE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				esfc_pkg::REG_NODE0, esfc_pkg::REG_NODE1,
				esfc_pkg::REG_NODE2, esfc_pkg::REG_NODE3: node_q[cfg_index[1:0]] <= cfg_data[6:0];
				esfc_pkg::REG_HB_TIMEOUT: timeout_q <= cfg_data;
				esfc_pkg::REG_PDO_BASE:   base_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign hb_timeout = timeout_q;

	logic        hb_range;
	logic [11:0] pdo_diff;
	logic        pdo_range;
	logic        hb_found;
	logic [1:0]  hb_slot;
	logic        pdo_found;
	logic [1:0]  pdo_slot;

	assign hb_range  = (can_id > esfc_pkg::HB_BASE) && (can_id <= esfc_pkg::HB_TOP)
		&& (frame_length == esfc_pkg::HB_LEN);
	assign pdo_diff  = {1'b0, can_id} - {1'b0, base_q};
	// base < id <= base + 127
	assign pdo_range = !pdo_diff[11] && (pdo_diff[10:7] == 4'd0) && (pdo_diff[6:0] != 7'd0);

	// lowest matching slot wins, node zero matches nothing
	always_comb begin
		hb_found  = 1'b0;
		hb_slot   = '0;
		pdo_found = 1'b0;
		pdo_slot  = '0;
		for (int i = ACTIVE - 1; i >= 0; i--) begin
			if (node_q[i] != 7'd0 && node_q[i] == can_id[6:0]) begin
				hb_found = 1'b1;
				hb_slot  = 2'(i);
			end
			if (node_q[i] != 7'd0 && node_q[i] == pdo_diff[6:0]) begin
				pdo_found = 1'b1;
				pdo_slot  = 2'(i);
			end
		end
	end

	always_comb begin
		entry.cmd      = cmd;
		entry.hb_hit   = hb_range && hb_found;
		entry.hb_slot  = hb_slot;
		entry.pdo_hit  = pdo_range && pdo_found;
		entry.pdo_slot = pdo_slot;
		entry.len_ok   = (frame_length == esfc_pkg::POS_LEN);
		entry.payload  = payload_low;
		entry.rx_time  = rx_time;
	end

endmodule

>>> hw/rtl/esfc_queue.sv
// Short FIFO of classified items between front and back.
module esfc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  esfc_pkg::entry_t  push_data,
	output logic              full,
	input  logic              pop,
	output esfc_pkg::entry_t  head,
	output logic              head_valid
);

	localparam int PW = $clog2(esfc_pkg::QDEPTH);

	esfc_pkg::entry_t mem_q [esfc_pkg::QDEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [PW:0]      count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == (PW+1)'(esfc_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

>>> hw/rtl/esfc_back.sv
// Back end: cycle state, heartbeat tracking, counters and result sequencing.
module esfc_back #(
	parameter int MODULES = esfc_pkg::MODULES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esfc_pkg::entry_t   head,
	input  logic               head_valid,
	output logic               pop,
	input  logic [15:0]        hb_timeout,
	input  logic               out_ready,
	output logic               out_valid,
	output esfc_pkg::result_t  out_data
);

	localparam int ACTIVE = (MODULES < esfc_pkg::SLOTS) ? MODULES : esfc_pkg::SLOTS;
	localparam int SW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	logic [31:0] time_q;
	logic [31:0] start_q;
	logic [31:0] tdiff_q;   // time_q - start_q, kept incrementally
	logic [31:0] pos_q    [ACTIVE];
	logic [31:0] stamp_q  [ACTIVE];
	logic [7:0]  nstate_q [ACTIVE];
	logic [ACTIVE-1:0] pseen_q;
	logic [ACTIVE-1:0] hbseen_q;
	logic [15:0] cnt_q [4];
	logic [1:0]  idx_q;

	esfc_pkg::result_t out_q;
	logic              out_valid_q;

	logic        out_free;
	logic [31:0] d;
	logic        pre_start;
	logic [SW-1:0] rsel;
	logic [31:0] age;
	logic        alive;
	logic        last_beat;
	logic        load;
	esfc_pkg::result_t res;
	logic        do_frame;
	logic        do_tick;
	logic        do_start;
	logic        do_beat;

	assign out_free  = !out_valid_q || out_ready;
	assign d         = start_q - head.rx_time;
	assign pre_start = (head.rx_time != 32'd0) && (d != 32'd0) && !d[31];
	assign rsel      = idx_q[SW-1:0];
	assign age       = time_q - stamp_q[rsel];
	assign alive     = hbseen_q[rsel] && (age < {16'd0, hb_timeout});
	assign last_beat = (idx_q == 2'(ACTIVE - 1));

	always_comb begin
		do_frame = 1'b0;
		do_tick  = 1'b0;
		do_start = 1'b0;
		do_beat  = 1'b0;
		pop      = 1'b0;
		if (head_valid) begin
			unique case (head.cmd)
				esfc_pkg::CMD_FRAME: begin
					do_frame = 1'b1;
					pop      = 1'b1;
				end
				esfc_pkg::CMD_TICK: begin
					do_tick = 1'b1;
					pop     = 1'b1;
				end
				esfc_pkg::CMD_START: begin
					do_start = out_free;
					pop      = out_free;
				end
				esfc_pkg::CMD_REPORT: begin
					do_beat = out_free;
					pop     = out_free && last_beat;
				end
				default: ;
			endcase
		end
	end

	assign load = do_start || do_beat;

	always_comb begin
		res = '0;
		if (do_start) begin
			res.kind        = esfc_pkg::KIND_SYNC;
			res.sync_can_id = esfc_pkg::SYNC_ID;
			res.last        = 1'b1;
		end else begin
			res.kind            = esfc_pkg::KIND_REPORT;
			res.module_index    = idx_q;
			res.position        = pos_q[rsel];
			res.position_valid  = pseen_q[rsel];
			res.heartbeat_alive = alive;
			res.hb_state        = nstate_q[rsel];
			res.stale_count     = cnt_q[esfc_pkg::CNT_STALE];
			res.unknown_count   = cnt_q[esfc_pkg::CNT_UNKNOWN];
			res.rejected_count  = cnt_q[esfc_pkg::CNT_REJECT];
			res.duplicate_count = cnt_q[esfc_pkg::CNT_DUP];
			res.last            = last_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_beat) begin
				idx_q <= last_beat ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			start_q  <= '0;
			tdiff_q  <= '0;
			pseen_q  <= '0;
			hbseen_q <= '0;
			for (int i = 0; i < ACTIVE; i++) begin
				pos_q[i]    <= '0;
				stamp_q[i]  <= '0;
				nstate_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (do_tick) begin
				time_q  <= time_q + 32'd1;
				tdiff_q <= tdiff_q + 32'd1;
			end
			if (do_start) begin
				start_q <= time_q;
				tdiff_q <= '0;
				pseen_q <= '0;
				for (int i = 0; i < ACTIVE; i++) begin
					pos_q[i] <= '0;
				end
				for (int i = 0; i < 4; i++) begin
					cnt_q[i] <= '0;
				end
			end
			if (do_frame) begin
				if (head.hb_hit) begin
					// stamp = time_now - age; for an old frame that is tdiff + rx_time
					stamp_q[head.hb_slot[SW-1:0]]  <= pre_start ? tdiff_q + head.rx_time : time_q;
					hbseen_q[head.hb_slot[SW-1:0]] <= 1'b1;
					nstate_q[head.hb_slot[SW-1:0]] <= head.payload[7:0];
				end else if (pre_start) begin
					if (cnt_q[esfc_pkg::CNT_STALE] != esfc_pkg::CNT_MAX)
						cnt_q[esfc_pkg::CNT_STALE] <= cnt_q[esfc_pkg::CNT_STALE] + 16'd1;
				end else if (!head.pdo_hit) begin
					if (cnt_q[esfc_pkg::CNT_UNKNOWN] != esfc_pkg::CNT_MAX)
						cnt_q[esfc_pkg::CNT_UNKNOWN] <= cnt_q[esfc_pkg::CNT_UNKNOWN] + 16'd1;
				end else if (!head.len_ok) begin
					if (cnt_q[esfc_pkg::CNT_REJECT] != esfc_pkg::CNT_MAX)
						cnt_q[esfc_pkg::CNT_REJECT] <= cnt_q[esfc_pkg::CNT_REJECT] + 16'd1;
				end else if (pseen_q[head.pdo_slot[SW-1:0]]) begin
					if (cnt_q[esfc_pkg::CNT_DUP] != esfc_pkg::CNT_MAX)
						cnt_q[esfc_pkg::CNT_DUP] <= cnt_q[esfc_pkg::CNT_DUP] + 16'd1;
				end else begin
					pos_q[head.pdo_slot[SW-1:0]]   <= head.payload;
					pseen_q[head.pdo_slot[SW-1:0]] <= 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
